// ----- src/ookpf_pkg.sv -----
// Package for the OOK pulse-pair frame decoder: beat types, register map and
// fixed constants shared by the window, frame and top-level modules.
// No dependencies.
package ookpf_pkg;

	// Bits per collected word; two words make up a full frame.
	localparam int WORD_BITS = 64;
	localparam int FRAME_MAX = 2 * WORD_BITS;

	// Width of the configuration write data (widest register).
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_INDEX_W = 3;

	// Tolerance window is (nominal * percent) / 100. The divide by 100 is a
	// multiply by ceil(2^30 / 100) followed by a 30-bit shift, which is exact
	// for every product of a 16-bit duration and a 7-bit percentage.
	localparam int          TOL_PROD_W = 23;
	localparam int          TOL_W      = 17;
	localparam int          TOL_SHIFT  = 30;
	localparam logic [23:0] TOL_RECIP  = 24'd10737419;

	localparam logic [15:0] PULSE_INDEX_MAX = 16'hFFFF;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_SHORT_TIME        = 3'd0,
		CFG_LONG_TIME         = 3'd1,
		CFG_TOLERANCE_PERCENT = 3'd2,
		CFG_PREAMBLE_PULSES   = 3'd3,
		CFG_FRAME_BITS        = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [15:0] short_time;
		logic [15:0] long_time;
		logic [6:0]  tolerance_percent;
		logic [15:0] preamble_pulses;
		logic [7:0]  frame_bits;
	} cfg_t;

	typedef struct packed {
		logic [15:0] pulse_time;
		logic        last_pulse;
	} in_item_t;

	typedef struct packed {
		logic                 frame_ok;
		logic [WORD_BITS-1:0] frame_high;
		logic [WORD_BITS-1:0] frame_low;
		logic [7:0]           bit_total;
	} out_item_t;

	// Classification of one pulse against both nominal windows. The duration
	// and the windows travel along so that a held high pulse can be judged
	// against the windows in force when its low partner arrives.
	typedef struct packed {
		logic [15:0]      pulse_time;
		logic [TOL_W-1:0] tol_short;
		logic [TOL_W-1:0] tol_long;
		logic             is_short;
		logic             is_long;
		logic             last_pulse;
	} pulse_class_t;

endpackage

// ----- src/ookpf_window.sv -----
// Three-stage window pipeline: tolerance product, divide by 100 and window
// compares, giving a short/long classification for each pulse.
// Depends on ookpf_pkg.
module ookpf_window import ookpf_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  cfg_t         cfg,
	input  logic         in_valid,
	output logic         in_stall,
	input  in_item_t     in_data,
	output logic         cls_valid,
	input  logic         cls_ready,
	output pulse_class_t cls_data
);

	logic                  valid_s1, valid_s2, valid_s3;
	logic                  ready_s1, ready_s2, ready_s3;
	logic [15:0]           pulse_s1, pulse_s2;
	logic                  last_s1, last_s2;
	logic [15:0]           short_s1, short_s2;
	logic [15:0]           long_s1, long_s2;
	logic [TOL_PROD_W-1:0] prod_short_s1, prod_long_s1;
	logic [TOL_W-1:0]      tol_short_s2, tol_long_s2;
	logic [46:0]           recip_short, recip_long;
	logic [15:0]           diff_short, diff_long;
	pulse_class_t          cls_s3, cls_next;

	assign ready_s3 = !valid_s3 || cls_ready;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_stall = !ready_s1;

	assign recip_short = 47'(prod_short_s1) * 47'(TOL_RECIP);
	assign recip_long  = 47'(prod_long_s1) * 47'(TOL_RECIP);

	assign diff_short = (pulse_s2 > short_s2) ? pulse_s2 - short_s2 : short_s2 - pulse_s2;
	assign diff_long  = (pulse_s2 > long_s2) ? pulse_s2 - long_s2 : long_s2 - pulse_s2;

	always_comb begin
		cls_next.pulse_time = pulse_s2;
		cls_next.tol_short  = tol_short_s2;
		cls_next.tol_long   = tol_long_s2;
		cls_next.is_short   = {1'b0, diff_short} < tol_short_s2;
		cls_next.is_long    = {1'b0, diff_long} < tol_long_s2;
		cls_next.last_pulse = last_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1)
				valid_s1 <= in_valid;
			if (ready_s2)
				valid_s2 <= valid_s1;
			if (ready_s3)
				valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && ready_s1) begin
			pulse_s1      <= in_data.pulse_time;
			last_s1       <= in_data.last_pulse;
			short_s1      <= cfg.short_time;
			long_s1       <= cfg.long_time;
			prod_short_s1 <= TOL_PROD_W'(cfg.short_time) * TOL_PROD_W'(cfg.tolerance_percent);
			prod_long_s1  <= TOL_PROD_W'(cfg.long_time) * TOL_PROD_W'(cfg.tolerance_percent);
		end
		if (valid_s1 && ready_s2) begin
			pulse_s2     <= pulse_s1;
			last_s2      <= last_s1;
			short_s2     <= short_s1;
			long_s2      <= long_s1;
			tol_short_s2 <= recip_short[TOL_SHIFT +: TOL_W];
			tol_long_s2  <= recip_long[TOL_SHIFT +: TOL_W];
		end
		if (valid_s2 && ready_s3)
			cls_s3 <= cls_next;
	end

	assign cls_valid = valid_s3;
	assign cls_data  = cls_s3;

endmodule

// ----- src/ookpf_frame.sv -----
// Capture state: preamble skip, pair classification into bits, the two frame
// words and the result register toward the output channel.
// Depends on ookpf_pkg.
module ookpf_frame import ookpf_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  cfg_t         cfg,
	input  logic         cls_valid,
	output logic         cls_ready,
	input  pulse_class_t cls_data,
	output logic         out_valid,
	input  logic         out_stall,
	output out_item_t    out_data
);

	logic [15:0]          pulse_index_q, n_pulse_index;
	logic [15:0]          held_high_q, n_held_high;
	logic [15:0]          held_diff_short, held_diff_long;
	logic                 held_short, held_long;
	logic [WORD_BITS-1:0] high_q, low_q, n_high, n_low;
	logic [7:0]           bits_seen_q, n_bits_seen;
	logic                 stopped_q, n_stopped;
	logic [7:0]           limit;
	logic                 out_free, consume, take_bit, bit_val, frame_ok;
	logic                 out_valid_q;
	out_item_t            out_data_q;

	assign out_free  = !out_valid_q || !out_stall;
	assign cls_ready = !cls_data.last_pulse || out_free;
	assign consume   = cls_valid && cls_ready;

	assign limit = (cfg.frame_bits < 8'(FRAME_MAX)) ? cfg.frame_bits : 8'(FRAME_MAX);

	// The held high pulse is judged against the windows of the low pulse's beat.
	assign held_diff_short = (held_high_q > cfg.short_time) ? held_high_q - cfg.short_time
		: cfg.short_time - held_high_q;
	assign held_diff_long  = (held_high_q > cfg.long_time) ? held_high_q - cfg.long_time
		: cfg.long_time - held_high_q;
	assign held_short = {1'b0, held_diff_short} < cls_data.tol_short;
	assign held_long  = {1'b0, held_diff_long} < cls_data.tol_long;

	always_comb begin
		n_pulse_index = pulse_index_q;
		n_held_high   = held_high_q;
		n_high        = high_q;
		n_low         = low_q;
		n_bits_seen   = bits_seen_q;
		n_stopped     = stopped_q;
		take_bit      = 1'b0;
		bit_val       = 1'b0;

		if (pulse_index_q == PULSE_INDEX_MAX) begin
			n_stopped = 1'b1;
		end else if (pulse_index_q >= cfg.preamble_pulses && !stopped_q &&
				bits_seen_q < limit) begin
			// Parity of the index relative to the preamble picks high or low pulse.
			if ((pulse_index_q[0] ^ cfg.preamble_pulses[0]) == 1'b0) begin
				n_held_high = cls_data.pulse_time;
			end else if (held_short && cls_data.is_long) begin
				take_bit = 1'b1;
				bit_val  = 1'b0;
			end else if (held_long && cls_data.is_short) begin
				take_bit = 1'b1;
				bit_val  = 1'b1;
			end else begin
				n_stopped = 1'b1;
			end
		end

		if (take_bit) begin
			if (bits_seen_q < 8'(WORD_BITS))
				n_high = {high_q[WORD_BITS-2:0], bit_val};
			else
				n_low = {low_q[WORD_BITS-2:0], bit_val};
			n_bits_seen = bits_seen_q + 8'd1;
		end

		if (pulse_index_q != PULSE_INDEX_MAX)
			n_pulse_index = pulse_index_q + 16'd1;

		frame_ok = (pulse_index_q >= cfg.preamble_pulses) && (n_bits_seen >= cfg.frame_bits);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_index_q <= '0;
			held_high_q   <= '0;
			high_q        <= '0;
			low_q         <= '0;
			bits_seen_q   <= '0;
			stopped_q     <= 1'b0;
		end else if (consume) begin
			if (cls_data.last_pulse) begin
				pulse_index_q <= '0;
				held_high_q   <= '0;
				high_q        <= '0;
				low_q         <= '0;
				bits_seen_q   <= '0;
				stopped_q     <= 1'b0;
			end else begin
				pulse_index_q <= n_pulse_index;
				held_high_q   <= n_held_high;
				high_q        <= n_high;
				low_q         <= n_low;
				bits_seen_q   <= n_bits_seen;
				stopped_q     <= n_stopped;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (consume && cls_data.last_pulse) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && cls_data.last_pulse) begin
			out_data_q.frame_ok   <= frame_ok;
			out_data_q.frame_high <= n_high;
			out_data_q.frame_low  <= n_low;
			out_data_q.bit_total  <= n_bits_seen;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef NO_ASSERTIONS
	a_bits_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		bits_seen_q <= 8'(FRAME_MAX))
		else $error("collected bit count exceeds two words");

	a_stopped_holds: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q && !(consume && cls_data.last_pulse) |=> $stable(bits_seen_q))
		else $error("bits collected after collection stopped");

	a_high_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		bits_seen_q >= 8'(WORD_BITS) && !(consume && cls_data.last_pulse) |=> $stable(high_q))
		else $error("high word changed after it was full");

	a_clear_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		consume && cls_data.last_pulse |=> pulse_index_q == '0 && bits_seen_q == '0 && out_valid_q)
		else $error("capture not cleared or result missing after last pulse");
`endif

endmodule

// ----- src/ook_pwm_pulse_pair_frame_decoder_unit.sv -----
// Top level of the OOK pulse-pair frame decoder: configuration registers,
// window pipeline and frame state.
// Depends on ookpf_pkg, ookpf_window and ookpf_frame.
//
//   Channel   Direction   Handshake            Beat
//   in        input       in_valid/in_stall    in_item_t (pulse_time, last_pulse)
//   out       output      out_valid/out_stall  out_item_t (frame_ok, words, bit_total)
//   cfg       input       cfg_we               cfg_index, cfg_data
//
// One pulse is accepted per cycle while in_stall is low. An accepted pulse goes
// through tolerance product, divide by 100 and window compares to the capture
// state; a last pulse places its result in the output register as it is taken there.
// Reset clears the pipeline, the capture state and the output valid, and loads the
// register defaults. A stalled output holds only last-pulse beats at the capture
// stage; other pulses keep flowing while a result waits.
module ook_pwm_pulse_pair_frame_decoder_unit import ookpf_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  in_item_t               in_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output out_item_t              out_data
);

	cfg_t         cfg_q;
	logic         cls_valid, cls_ready;
	pulse_class_t cls_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_time        <= 16'd300;
			cfg_q.long_time         <= 16'd600;
			cfg_q.tolerance_percent <= 7'd25;
			cfg_q.preamble_pulses   <= 16'd0;
			cfg_q.frame_bits        <= 8'd128;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SHORT_TIME:        cfg_q.short_time        <= cfg_data;
				CFG_LONG_TIME:         cfg_q.long_time         <= cfg_data;
				CFG_TOLERANCE_PERCENT: cfg_q.tolerance_percent <= cfg_data[6:0];
				CFG_PREAMBLE_PULSES:   cfg_q.preamble_pulses   <= cfg_data;
				CFG_FRAME_BITS:        cfg_q.frame_bits        <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	ookpf_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.cls_valid (cls_valid),
		.cls_ready (cls_ready),
		.cls_data  (cls_data)
	);

	ookpf_frame u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cls_valid (cls_valid),
		.cls_ready (cls_ready),
		.cls_data  (cls_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

// ----- tb/testbench.sv -----
// Self-checking bench for the OOK pulse-pair frame decoder top level.
// It drives pulse beats and register writes, predicts each frame result in a
// small tracker class and checks every result beat. Depends on ookpf_pkg and the top level.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ookpf_pkg::*;

	localparam int RANDOM_PULSES = 1950;
	localparam int IDLE_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 8;
	localparam int CFG_SPARE_FIRST = CFG_FRAME_BITS + 1;
	localparam int CFG_SPARE_LAST = (1 << CFG_INDEX_W) - 1;

	class capture_tracker;
		logic [15:0] short_t;
		logic [15:0] long_t;
		logic [6:0]  tol_pct;
		logic [15:0] preamble;
		logic [7:0]  frame_req;

		logic [15:0] pulse_idx;
		logic [15:0] held_high;
		logic [63:0] high_w;
		logic [63:0] low_w;
		logic [7:0]  bits_seen;
		logic        stopped;

		out_item_t frames_due[$];
		int mismatches;

		function new();
			short_t = 16'd300;
			long_t = 16'd600;
			tol_pct = 7'd25;
			preamble = 16'd0;
			frame_req = 8'd128;
			mismatches = 0;
			clear_capture();
		endfunction

		function void clear_capture();
			pulse_idx = '0;
			held_high = '0;
			high_w = '0;
			low_w = '0;
			bits_seen = '0;
			stopped = 1'b0;
		endfunction

		function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [15:0] value);
			case (index)
				CFG_SHORT_TIME: short_t = value;
				CFG_LONG_TIME: long_t = value;
				CFG_TOLERANCE_PERCENT: tol_pct = value[6:0];
				CFG_PREAMBLE_PULSES: preamble = value;
				CFG_FRAME_BITS: frame_req = value[7:0];
				default: ;
			endcase
		endfunction

		function int window(logic [15:0] nominal);
			return (int'(nominal) * int'(tol_pct)) / 100;
		endfunction

		function bit in_window(logic [15:0] t, logic [15:0] nominal);
			int diff;
			diff = int'(t) - int'(nominal);
			if (diff < 0)
				diff = -diff;
			return diff < window(nominal);
		endfunction

		function void note_pulse(in_item_t beat);
			logic [15:0] idx;
			logic [15:0] rel;
			logic bit_val;
			bit matched;
			int cap;
			out_item_t res;
			idx = pulse_idx;
			cap = (int'(frame_req) < FRAME_MAX) ? int'(frame_req) : FRAME_MAX;
			matched = 1'b0;
			bit_val = 1'b0;
			if (idx == PULSE_INDEX_MAX) begin
				stopped = 1'b1;
			end else if (idx >= preamble && !stopped && int'(bits_seen) < cap) begin
				rel = idx - preamble;
				if (!rel[0]) begin
					held_high = beat.pulse_time;
				end else if (in_window(held_high, short_t) && in_window(beat.pulse_time, long_t)) begin
					matched = 1'b1;
				end else if (in_window(held_high, long_t) && in_window(beat.pulse_time, short_t)) begin
					matched = 1'b1;
					bit_val = 1'b1;
				end else begin
					stopped = 1'b1;
				end
				if (matched) begin
					if (bits_seen < WORD_BITS)
						high_w = {high_w[62:0], bit_val};
					else
						low_w = {low_w[62:0], bit_val};
					bits_seen++;
				end
			end
			if (pulse_idx != PULSE_INDEX_MAX)
				pulse_idx++;
			if (beat.last_pulse) begin
				res.frame_ok = (idx >= preamble) && (bits_seen >= frame_req);
				res.frame_high = high_w;
				res.frame_low = low_w;
				res.bit_total = bits_seen;
				frames_due.push_back(res);
				clear_capture();
			end
		endfunction

		function void check_frame(out_item_t got);
			out_item_t want;
			if (frames_due.size() == 0) begin
				$error("result beat with no frame pending: frame_ok %0d bit_total %0d",
					got.frame_ok, got.bit_total);
				mismatches++;
				return;
			end
			want = frames_due.pop_front();
			if (got.frame_ok !== want.frame_ok) begin
				$error("frame_ok: expected %0d, got %0d", want.frame_ok, got.frame_ok);
				mismatches++;
			end
			if (got.frame_high !== want.frame_high) begin
				$error("frame_high: expected %h, got %h", want.frame_high, got.frame_high);
				mismatches++;
			end
			if (got.frame_low !== want.frame_low) begin
				$error("frame_low: expected %h, got %h", want.frame_low, got.frame_low);
				mismatches++;
			end
			if (got.bit_total !== want.bit_total) begin
				$error("bit_total: expected %0d, got %0d", want.bit_total, got.bit_total);
				mismatches++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;

	capture_tracker tracker = new();
	int pulses_sent = 0;
	int idle_cycles = 0;
	int stall_left = 0;
	bit in_idle_on = 1'b1;
	bit out_idle_on = 1'b1;

	always #1 clk = ~clk;

	ook_pwm_pulse_pair_frame_decoder_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	// The stall count is drawn when a result beat is taken and is spent only
	// while the next result is waiting, so the hold always lands on a result.
	always @(posedge clk) begin : result_side
		int gap;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else if (out_valid && !out_stall) begin
			tracker.check_frame(out_data);
			gap = out_idle_on ? $urandom_range(0, 5) : 0;
			stall_left <= gap;
			out_stall <= (gap != 0);
		end else if (out_valid && stall_left > 0) begin
			stall_left <= stall_left - 1;
			if (stall_left == 1)
				out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("[ook_pwm_pulse_pair_frame_decoder_unit] ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_pulse(input logic [15:0] duration, input logic last);
		in_item_t beat;
		int gap;
		beat.pulse_time = duration;
		beat.last_pulse = last;
		gap = in_idle_on ? $urandom_range(0, 5) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= beat;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		tracker.note_pulse(beat);
		pulses_sent++;
	endtask

	task automatic send_train(input logic [15:0] train[$]);
		for (int i = 0; i < train.size(); i++)
			send_pulse(train[i], i == train.size() - 1);
	endtask

	// Registers only change once every pending frame is out and the window
	// pipeline has had time to empty.
	task automatic settle();
		in_valid <= 1'b0;
		while (tracker.frames_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [15:0] value);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		tracker.write_reg(index, value);
	endtask

	task automatic apply_settings(input logic [15:0] st, lt, tol_data, pre, fb_data);
		write_reg(CFG_INDEX_W'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)),
			16'($urandom));
		write_reg(CFG_SHORT_TIME, st);
		write_reg(CFG_LONG_TIME, lt);
		write_reg(CFG_TOLERANCE_PERCENT, tol_data);
		write_reg(CFG_PREAMBLE_PULSES, pre);
		write_reg(CFG_FRAME_BITS, fb_data);
		cfg_we <= 1'b0;
	endtask

	task automatic random_settings();
		int st, lt, tol, pre, fb;
		st = $urandom_range(50, 2000);
		lt = st * $urandom_range(2, 3) + $urandom_range(0, 50);
		tol = $urandom_range(5, 40);
		pre = $urandom_range(0, 6);
		case ($urandom_range(0, 11))
			0: tol = $urandom_range(101, 127);
			1: begin
				st = $urandom_range(20000, 65535);
				lt = $urandom_range(0, 65535);
				tol = $urandom_range(0, 127);
			end
			2: tol = 0;
			3: lt = st;
			4: begin
				st = $urandom_range(0, 8);
				lt = $urandom_range(30000, 65535);
			end
			5: pre = $urandom_range(30, 50);
			default: ;
		endcase
		case ($urandom_range(0, 11))
			0: fb = 0;
			1: fb = 1;
			2: fb = 64;
			3: fb = 65;
			4: fb = 128;
			5: fb = $urandom_range(129, 255);
			6: fb = 127;
			default: fb = $urandom_range(2, 24);
		endcase
		// Unused upper data bits are randomized for the narrow registers.
		apply_settings(16'(st), 16'(lt), {9'($urandom), 7'(tol)}, 16'(pre),
			{8'($urandom), 8'(fb)});
	endtask

	// A duration inside the window of a nominal when tol is nonzero; with edgy set it is often
	// right on the boundary, one tick inside or exactly at the tolerance.
	function automatic logic [15:0] near_pulse(int nominal, int tol, bit edgy);
		int lo, hi;
		if (edgy && $urandom_range(0, 3) == 0)
			lo = $urandom_range(0, 1) ? nominal + tol : nominal - tol;
		else if (edgy && $urandom_range(0, 2) == 0)
			lo = $urandom_range(0, 1) ? nominal + tol - 1 : nominal - tol + 1;
		else if (tol == 0)
			lo = nominal;
		else begin
			lo = nominal - tol + 1;
			hi = nominal + tol - 1;
			if (lo < 0)
				lo = 0;
			if (hi > 65535)
				hi = 65535;
			lo = $urandom_range(lo, hi);
		end
		if (lo < 0)
			lo = 0;
		if (lo > 65535)
			lo = 65535;
		return 16'(lo);
	endfunction

	task automatic random_capture();
		logic [15:0] train[$];
		int kind, n_pre, cap, n_bits, tol_s, tol_l, st, lt;
		bit edgy;
		kind = $urandom_range(0, 9);
		edgy = (kind == 3);
		st = int'(tracker.short_t);
		lt = int'(tracker.long_t);
		tol_s = tracker.window(tracker.short_t);
		tol_l = tracker.window(tracker.long_t);
		n_pre = int'(tracker.preamble);
		if (kind == 4 && n_pre > 0)
			n_pre = $urandom_range(0, n_pre - 1);
		cap = (int'(tracker.frame_req) < FRAME_MAX) ? int'(tracker.frame_req) : FRAME_MAX;
		n_bits = ($urandom_range(0, 3) == 0) ? $urandom_range(0, cap + 2) : cap;
		repeat (n_pre) train.push_back(16'($urandom_range(0, 65535)));
		repeat (n_bits) begin
			if ($urandom_range(0, 1)) begin
				train.push_back(near_pulse(lt, tol_l, edgy));
				train.push_back(near_pulse(st, tol_s, edgy));
			end else begin
				train.push_back(near_pulse(st, tol_s, edgy));
				train.push_back(near_pulse(lt, tol_l, edgy));
			end
		end
		if (kind == 0 && n_bits > 0)
			train[n_pre + $urandom_range(0, 2 * n_bits - 1)] = 16'($urandom_range(0, 65535));
		if (kind == 1)
			train.push_back($urandom_range(0, 1) ? near_pulse(st, tol_s, 1'b0)
				: 16'($urandom_range(0, 65535)));
		if (kind == 2) begin
			train.delete();
			repeat ($urandom_range(1, 8)) train.push_back(16'($urandom_range(0, 65535)));
		end
		if (train.size() == 0)
			train.push_back(16'($urandom_range(0, 65535)));
		send_train(train);
	endtask

	initial begin : stimulus
		logic [15:0] train[$];
		int ncap;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset defaults: bit 0, bit 1, a pair one tick inside both windows,
		// then a high exactly at the short tolerance, which ends collection.
		train = '{16'd300, 16'd600, 16'd600, 16'd300, 16'd226, 16'd451,
			16'd225, 16'd600, 16'd0, 16'd65535};
		send_train(train);
		// A capture of one unpaired high pulse.
		train = '{16'd300};
		send_train(train);

		// Zero short window, widest tolerance, a preamble and zero frame bits:
		// success once the preamble is passed, failure inside it.
		settle();
		apply_settings(16'd0, 16'd65535, 16'd127, 16'd2, 16'd0);
		train = '{16'd65535, 16'd0, 16'd0, 16'd65535};
		send_train(train);
		train = '{16'd7};
		send_train(train);

		// Tolerance of 100 percent makes the windows overlap.
		settle();
		apply_settings(16'd1000, 16'd2000, 16'd100, 16'd0, 16'd2);
		train = '{16'd1000, 16'd2000, 16'd2000, 16'd1000, 16'd0, 16'd65535};
		send_train(train);

		pulses_sent = 0;
		while (pulses_sent < RANDOM_PULSES) begin
			settle();
			in_idle_on = ($urandom_range(0, 4) != 0);
			out_idle_on = ($urandom_range(0, 4) != 0);
			random_settings();
			ncap = (tracker.frame_req >= 64) ? $urandom_range(1, 2) : $urandom_range(3, 8);
			repeat (ncap) random_capture();
		end
		settle();

		if (tracker.mismatches == 0)
			$display("[ook_pwm_pulse_pair_frame_decoder_unit] OK");
		else
			$display("[ook_pwm_pulse_pair_frame_decoder_unit] ERROR");
		$finish;
	end
endmodule

// ----- filelist.f -----
src/ookpf_pkg.sv
src/ookpf_window.sv
src/ookpf_frame.sv
src/ook_pwm_pulse_pair_frame_decoder_unit.sv
tb/testbench.sv
